@@ src/lpar_pkg.sv @@
`timescale 1ns / 1ps

package lpar_pkg;

  // Link phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RX    = 3'd1,
    PH_TX    = 3'd2,
    PH_AWAIT = 3'd3,
    PH_ACKTX = 3'd4,
    PH_DUMMY = 3'd5
  } phase_t;

  // Bus event codes
  localparam logic [2:0] CMD_RD_START = 3'd0;
  localparam logic [2:0] CMD_WR_START = 3'd1;
  localparam logic [2:0] CMD_XFER_OK  = 3'd2;
  localparam logic [2:0] CMD_XFER_ERR = 3'd3;
  localparam logic [2:0] CMD_QUEUE    = 3'd4;

  // Send completion status
  localparam logic [1:0] SENT_NONE   = 2'd0;
  localparam logic [1:0] SENT_OK     = 2'd1;
  localparam logic [1:0] SENT_FAILED = 2'd2;

  // Delivery target of a received payload
  localparam logic [1:0] DLV_NONE = 2'd0;
  localparam logic [1:0] DLV_NET  = 2'd1;
  localparam logic [1:0] DLV_LINK = 2'd2;

  localparam int HDR_W  = 11;
  localparam int TRY_W  = 4;
  localparam int CMD_W  = 3;

  // Header bit positions
  localparam int HDR_ACK   = 10;
  localparam int HDR_DUMMY = 9;
  localparam int HDR_FIRST = 8;
  localparam int HDR_VALID = 7;
  localparam int HDR_TYPE  = 6;

  localparam logic [TRY_W-1:0] RETRY_DEFAULT = 4'd3;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    phase_t             phase;
    logic [HDR_W-1:0]   hdr;
    logic [TRY_W-1:0]   tries;
    logic               req;
    logic               armed;
  } link_st_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [HDR_W-1:0]   rx_hdr;
    logic               crc_ok;
    logic               msg_kind;
  } link_req_t;

  typedef struct packed {
    logic [1:0]         sent;
    logic [1:0]         dlv;
  } link_rpt_t;

endpackage

@@ src/lpar_step.sv @@
`timescale 1ns / 1ps

// One event applied to the link state, handler re-entries folded in.
module lpar_step
  import lpar_pkg::*;
(
  input  link_st_t          st_i,
  input  link_req_t         req_i,
  input  logic [TRY_W-1:0]  retry_limit_i,
  output link_st_t          st_o,
  output link_rpt_t         rpt_o
);

  always_comb begin
    link_st_t        s;
    logic [1:0]      sent;
    logic [1:0]      dlv;
    logic            do_retry;
    logic            rx_good;
    logic            hdr_ready;

    s         = st_i;
    sent      = SENT_NONE;
    dlv       = DLV_NONE;
    do_retry  = 1'b0;
    hdr_ready = 1'b0;
    rx_good   = req_i.crc_ok && req_i.rx_hdr[HDR_VALID];

    case (req_i.cmd)
      CMD_RD_START: begin
        if (s.phase == PH_AWAIT) begin
          // read start ends the wait: message taken as delivered
          s.hdr   = '0;
          s.tries = retry_limit_i;
          if (s.armed) sent = SENT_OK;
          s.armed = 1'b0;
          s.phase = PH_IDLE;
        end
        hdr_ready = s.hdr[HDR_VALID] && s.hdr[HDR_FIRST];
        if (s.phase == PH_ACKTX) begin
          s.req = 1'b0;
          if (!hdr_ready) s.hdr = HDR_W'(1) << HDR_DUMMY;
          s.hdr[HDR_ACK] = 1'b1;
        end else if (hdr_ready) begin
          s.req   = 1'b0;
          s.phase = PH_TX;
        end else begin
          s.hdr   = HDR_W'(1) << HDR_DUMMY;
          s.phase = PH_DUMMY;
        end
      end
      CMD_WR_START: begin
        if (s.phase != PH_AWAIT) s.phase = PH_RX;
      end
      CMD_XFER_OK: begin
        case (s.phase)
          PH_RX, PH_AWAIT: begin
            if (s.phase == PH_AWAIT) begin
              if (req_i.rx_hdr[HDR_ACK]) begin
                s.hdr   = '0;
                s.tries = retry_limit_i;
                if (s.armed) sent = SENT_OK;
                s.armed = 1'b0;
              end else begin
                do_retry = 1'b1;
              end
            end
            if (rx_good) begin
              if (req_i.rx_hdr[HDR_FIRST])
                dlv = req_i.rx_hdr[HDR_TYPE] ? DLV_NET : DLV_LINK;
              s.phase = PH_ACKTX;
            end else begin
              s.phase = PH_IDLE;
            end
          end
          PH_TX: s.phase = PH_AWAIT;
          PH_ACKTX: begin
            if (s.hdr[HDR_VALID]) begin
              s.phase = PH_AWAIT;
            end else begin
              s.hdr   = '0;
              s.tries = retry_limit_i;
              s.phase = PH_IDLE;
            end
          end
          PH_DUMMY: begin
            s.hdr   = '0;
            s.tries = retry_limit_i;
            s.phase = PH_IDLE;
          end
          default: s.phase = PH_IDLE;
        endcase
      end
      CMD_XFER_ERR: begin
        case (s.phase)
          PH_RX: s.phase = PH_IDLE;
          PH_TX, PH_AWAIT: begin
            do_retry = 1'b1;
            s.phase  = PH_IDLE;
          end
          PH_ACKTX: begin
            if (s.hdr[HDR_VALID]) begin
              do_retry = 1'b1;
            end else begin
              s.hdr   = '0;
              s.tries = retry_limit_i;
            end
            s.phase = PH_IDLE;
          end
          PH_DUMMY: begin
            s.hdr   = '0;
            s.tries = retry_limit_i;
            s.phase = PH_IDLE;
          end
          default: s.phase = PH_IDLE;
        endcase
      end
      CMD_QUEUE: begin
        s.hdr = '0;
        s.hdr[HDR_FIRST] = 1'b1;
        s.hdr[HDR_VALID] = 1'b1;
        s.hdr[HDR_TYPE]  = req_i.msg_kind;
        s.armed = 1'b1;
        s.req   = 1'b1;
      end
      default: begin
        // unknown event: state left alone
      end
    endcase

    if (do_retry) begin
      if (s.tries <= TRY_W'(1)) begin
        s.hdr   = '0;
        s.tries = retry_limit_i;
        if (s.armed) sent = SENT_FAILED;
        s.armed = 1'b0;
      end else begin
        s.tries = s.tries - TRY_W'(1);
        s.req   = 1'b1;
      end
    end

    st_o       = s;
    rpt_o.sent = sent;
    rpt_o.dlv  = dlv;
  end

endmodule

@@ src/link_packet_ack_retry_fsm_top.sv @@
`timescale 1ns / 1ps

// Slave-side link-layer transaction machine for a two-wire packet bus. Each
// request on the input stream is one bus event (in_tuser: read start, write
// start, transfer ok, transfer error, queue message) and yields exactly one
// result: the link phase after the event, the header the next transmit
// carries (dummy and ack bits included), the interrupt-request level, the
// send completion status and where a received payload goes. Requests go
// through an input register and then a result register before the result is
// presented on the output; while the output is not stalled one request is
// taken every cycle, the limit being the update of the phase/header/retry
// registers. retry_limit (cfg_wr_en/cfg_wr_data, reset 3) is picked up the
// next time the retry counter reloads; write it only while no request is in
// flight. CRC checking happens outside: its verdict arrives as crc_ok.
module link_packet_ack_retry_fsm_top
  import lpar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [10:0] rx_header, [11] crc_ok, [12] msg_kind, [15:13] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // [2:0] command
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] link_state, [13:3] send_header, [14] irq_line, [16:15] sent_status,
  // [18:17] deliver, [23:19] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [TRY_W-1:0]       cfg_wr_data
);

  logic [TRY_W-1:0]      retry_limit_r;

  // input register
  logic                  s1_valid_r;
  link_req_t             s1_req_r;

  // link state
  link_st_t              st_r;
  link_st_t              st_nxt;
  link_rpt_t             rpt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  logic                  s1_fire;

  // stage 1 moves on when the result register is free or being drained
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_DEFAULT;
    end else if (cfg_wr_en) begin
      retry_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r.cmd      <= in_tuser;
      s1_req_r.rx_hdr   <= in_tdata[HDR_W-1:0];
      s1_req_r.crc_ok   <= in_tdata[HDR_W];
      s1_req_r.msg_kind <= in_tdata[HDR_W+1];
    end
  end

  lpar_step u_step (
    .st_i          (st_r),
    .req_i         (s1_req_r),
    .retry_limit_i (retry_limit_r),
    .st_o          (st_nxt),
    .rpt_o         (rpt)
  );

  // state commits only when the request's result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_IDLE;
      st_r.hdr   <= '0;
      st_r.tries <= RETRY_DEFAULT;
      st_r.req   <= 1'b0;
      st_r.armed <= 1'b0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  assign out_data_nxt = {5'd0, rpt.dlv, rpt.sent, st_nxt.req, st_nxt.hdr, st_nxt.phase};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/lpar_checker.sv @@
`timescale 1ns / 1ps

module lpar_checker
  import lpar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_DATA_W-1:0]  out_tdata
);

  // no stale result survives a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a payload is only handed on once the block moves to sending its ack
  a_deliver_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[18:17] != DLV_NONE) |-> out_tdata[2:0] == PH_ACKTX)
    else $error("delivery without ack phase");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:15] != 2'd3)
    else $error("bad send status code");

endmodule

bind link_packet_ack_retry_fsm_top lpar_checker u_lpar_checker (.*);
